FILE: rtl/dtq_pkg.sv
// Shared types and constants of the deadline timer queue.
// Used by dtq_store, dtq_ctrl and deadline_timer_queue; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dtq_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DL_W   = 64;
  localparam int TAG_W  = 32;
  localparam int KIND_W = 2;
  localparam int CFG_W  = 32;

  localparam logic [KIND_W-1:0] KIND_ADD_OK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD_FULL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXPIRED  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DONE     = 2'd3;

  localparam logic REG_TASK_TAG    = 1'b0;
  localparam logic REG_TASK_PERIOD = 1'b1;

  // Request from the sequencer to the timer store; positions are logical,
  // counted from the earliest timer.
  typedef struct packed {
    logic             rd_en;
    logic [CNT_W-1:0] rd_pos;
    logic             wr_en;
    logic [CNT_W-1:0] wr_pos;
    logic [DL_W-1:0]  wr_dl;
    logic [TAG_W-1:0] wr_tag;
    logic             pop;
    logic             push;
  } store_req_t;

  typedef struct packed {
    logic [DL_W-1:0]  dl;
    logic [TAG_W-1:0] tag;
    logic [CNT_W-1:0] occ;
  } store_rsp_t;

  typedef struct packed {
    logic              load;
    logic [KIND_W-1:0] kind;
    logic [DL_W-1:0]   dl;
    logic [TAG_W-1:0]  tag;
    logic              sw;
    logic              last;
  } out_req_t;

endpackage

`default_nettype wire

FILE: rtl/dtq_store.sv
// Sorted timer store: ring buffer memory with head pointer and fill count.
// Depends on dtq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtq_store
  import dtq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire store_req_t req,
  output store_rsp_t      rsp
);

  logic [DL_W+TAG_W-1:0] mem [DEPTH];
  logic [DL_W+TAG_W-1:0] rd_q;
  logic [IDX_W-1:0]      head;
  logic [CNT_W-1:0]      occ;
  logic [IDX_W-1:0]      rd_phys;
  logic [IDX_W-1:0]      wr_phys;

  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] h,
                                            input logic [CNT_W-1:0] pos);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(h) + (CNT_W+1)'(pos);
    if (s >= (CNT_W+1)'(DEPTH)) begin
      s = s - (CNT_W+1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  assign rd_phys = phys(head, req.rd_pos);
  assign wr_phys = phys(head, req.wr_pos);

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[wr_phys] <= {req.wr_dl, req.wr_tag};
    end
    if (req.rd_en) begin
      rd_q <= mem[rd_phys];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      occ  <= '0;
    end else if (req.pop) begin
      head <= (head == IDX_W'(DEPTH - 1)) ? '0 : head + IDX_W'(1);
      occ  <= occ - CNT_W'(1);
    end else if (req.push) begin
      occ  <= occ + CNT_W'(1);
    end
  end

  assign rsp.dl  = rd_q[DL_W+TAG_W-1:TAG_W];
  assign rsp.tag = rd_q[TAG_W-1:0];
  assign rsp.occ = occ;

endmodule

`default_nettype wire

FILE: rtl/dtq_ctrl.sv
// Sequencer with the shared 64-bit adder and comparator, tick counter and
// configuration registers. Depends on dtq_pkg; drives dtq_store.
`timescale 1ns / 1ps
`default_nettype none

module dtq_ctrl
  import dtq_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             in_mode,
  input  wire logic [DL_W-1:0]  in_dl,
  input  wire logic [TAG_W-1:0] in_tag,
  input  wire logic             cfg_we,
  input  wire logic             cfg_sel,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  input  wire logic             out_free,
  output out_req_t              out_req,
  output store_req_t            req,
  input  wire store_rsp_t       rsp
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_POP_RD  = 3'd1;
  localparam logic [2:0] S_POP_CMP = 3'd2;
  localparam logic [2:0] S_REARM   = 3'd3;
  localparam logic [2:0] S_INS_RD  = 3'd4;
  localparam logic [2:0] S_INS_CMP = 3'd5;
  localparam logic [2:0] S_RESULT  = 3'd6;

  logic [2:0]        state, state_next;
  logic [DL_W-1:0]   tick, tick_next;
  logic [TAG_W-1:0]  task_tag;
  logic [CFG_W-1:0]  task_period;
  logic [DL_W-1:0]   ins_dl, ins_dl_next;
  logic [TAG_W-1:0]  ins_tag, ins_tag_next;
  logic [CNT_W-1:0]  ins_pos, ins_pos_next;
  logic              is_add, is_add_next;
  logic [CNT_W-1:0]  rearm_cnt, rearm_cnt_next;
  logic              sw, sw_next;
  logic [KIND_W-1:0] res_kind, res_kind_next;
  logic              ins_done;

  logic [DL_W-1:0]   add_b;
  logic [DL_W-1:0]   add_sum;
  logic [DL_W-1:0]   cmp_b;
  logic              cmp_le;

  // shared adder: tick increment in idle, re-arm deadline otherwise
  assign add_b   = (state == S_IDLE) ? DL_W'(1) : DL_W'(task_period);
  assign add_sum = tick + add_b;
  // shared comparator: stored deadline against counter or new deadline
  assign cmp_b   = (state == S_POP_CMP) ? tick : ins_dl;
  assign cmp_le  = rsp.dl <= cmp_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      task_tag    <= 32'h8000_0000;
      task_period <= CFG_W'(2);
    end else if (cfg_we) begin
      unique case (cfg_sel)
        REG_TASK_TAG:    task_tag    <= cfg_wdata;
        REG_TASK_PERIOD: task_period <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next     = state;
    tick_next      = tick;
    ins_dl_next    = ins_dl;
    ins_tag_next   = ins_tag;
    ins_pos_next   = ins_pos;
    is_add_next    = is_add;
    rearm_cnt_next = rearm_cnt;
    sw_next        = sw;
    res_kind_next  = res_kind;
    ins_done       = 1'b0;
    in_ready       = 1'b0;
    req            = '0;
    out_req        = '0;

    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_mode) begin
            ins_dl_next  = in_dl;
            ins_tag_next = in_tag;
            is_add_next  = 1'b1;
            if (rsp.occ >= CNT_W'(DEPTH)) begin
              res_kind_next = KIND_ADD_FULL;
              state_next    = S_RESULT;
            end else begin
              ins_pos_next = rsp.occ;
              state_next   = S_INS_RD;
            end
          end else begin
            tick_next      = add_sum;
            sw_next        = 1'b0;
            rearm_cnt_next = '0;
            is_add_next    = 1'b0;
            state_next     = S_POP_RD;
          end
        end
      end
      S_POP_RD: begin
        if (rsp.occ == '0) begin
          state_next = S_REARM;
        end else begin
          req.rd_en  = 1'b1;
          req.rd_pos = '0;
          state_next = S_POP_CMP;
        end
      end
      S_POP_CMP: begin
        if (!cmp_le) begin
          state_next = S_REARM;
        end else if (rsp.tag == task_tag) begin
          req.pop        = 1'b1;
          rearm_cnt_next = rearm_cnt + CNT_W'(1);
          sw_next        = 1'b1;
          state_next     = S_POP_RD;
        end else if (out_free) begin
          req.pop      = 1'b1;
          out_req.load = 1'b1;
          out_req.kind = KIND_EXPIRED;
          out_req.dl   = rsp.dl;
          out_req.tag  = rsp.tag;
          state_next   = S_POP_RD;
        end
      end
      S_REARM: begin
        if (rearm_cnt == '0) begin
          res_kind_next = KIND_DONE;
          state_next    = S_RESULT;
        end else begin
          ins_dl_next  = add_sum;
          ins_tag_next = task_tag;
          ins_pos_next = rsp.occ;
          state_next   = S_INS_RD;
        end
      end
      S_INS_RD: begin
        if (ins_pos == '0) begin
          req.wr_en  = 1'b1;
          req.wr_pos = '0;
          req.wr_dl  = ins_dl;
          req.wr_tag = ins_tag;
          req.push   = 1'b1;
          ins_done   = 1'b1;
        end else begin
          req.rd_en  = 1'b1;
          req.rd_pos = ins_pos - CNT_W'(1);
          state_next = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        req.wr_en  = 1'b1;
        req.wr_pos = ins_pos;
        if (!cmp_le) begin
          req.wr_dl    = rsp.dl;
          req.wr_tag   = rsp.tag;
          ins_pos_next = ins_pos - CNT_W'(1);
          state_next   = S_INS_RD;
        end else begin
          req.wr_dl  = ins_dl;
          req.wr_tag = ins_tag;
          req.push   = 1'b1;
          ins_done   = 1'b1;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          out_req.load = 1'b1;
          out_req.kind = res_kind;
          out_req.sw   = (res_kind == KIND_DONE) && sw;
          out_req.last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (ins_done) begin
      if (is_add) begin
        res_kind_next = KIND_ADD_OK;
        state_next    = S_RESULT;
      end else begin
        rearm_cnt_next = rearm_cnt - CNT_W'(1);
        state_next     = S_REARM;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tick      <= '0;
      rearm_cnt <= '0;
      sw        <= 1'b0;
      is_add    <= 1'b0;
      res_kind  <= KIND_ADD_OK;
    end else begin
      state     <= state_next;
      tick      <= tick_next;
      rearm_cnt <= rearm_cnt_next;
      sw        <= sw_next;
      is_add    <= is_add_next;
      res_kind  <= res_kind_next;
    end
  end

  always_ff @(posedge clk) begin
    ins_dl  <= ins_dl_next;
    ins_tag <= ins_tag_next;
    ins_pos <= ins_pos_next;
  end

endmodule

`default_nettype wire

FILE: rtl/deadline_timer_queue.sv
// Top level of the deadline timer queue: stream ports, output register.
// Depends on dtq_pkg, dtq_store and dtq_ctrl.
//
// Requests enter on the s_ group: s_tuser selects tick (0) or add (1),
// s_tdata carries the deadline and tag of an add. Results leave on the
// m_ group with m_tlast on the final result of each request. Configuration
// writes (task tag, task period) enter on the cfg_ group, always ready.
// One request is in work at a time; s_tready is low until its final
// result is loaded. An add walks the store from the back, reading each
// stored timer with a later deadline and writing it one place up, then
// writes its own entry; a full store rejects the add at once. A tick
// advances the counter, pops each due timer, gives an expired result for
// each one without the task tag and re-inserts each task-tag timer with
// the deadline tick + task period.
// The output register holds one result; while m_tready is low the
// sequencer stalls with the next result pending and nothing is lost.
// Synchronous reset empties the store, clears the tick counter and sets
// the task tag to -2^31 and the task period to 2; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module deadline_timer_queue
  import dtq_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    s_tvalid,
  output logic                         s_tready,
  input  wire logic [DL_W+TAG_W-1:0]   s_tdata,   // tag, deadline
  input  wire logic                    s_tuser,   // mode
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  output logic [DL_W+TAG_W-1:0]        m_tdata,   // expired_tag, expired_deadline
  output logic [KIND_W:0]              m_tuser,   // task_switch, kind
  output logic                         m_tlast,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic                    cfg_index,
  input  wire logic [CFG_W-1:0]        cfg_data
);

  store_req_t req;
  store_rsp_t rsp;
  out_req_t   out_req;
  logic       out_free;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  dtq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_mode   (s_tuser),
    .in_dl     (s_tdata[DL_W-1:0]),
    .in_tag    (s_tdata[DL_W+TAG_W-1:DL_W]),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_sel   (cfg_index),
    .cfg_wdata (cfg_data),
    .out_free  (out_free),
    .out_req   (out_req),
    .req       (req),
    .rsp       (rsp)
  );

  dtq_store u_store (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_req.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_req.load) begin
      m_tdata <= {out_req.tag, out_req.dl};
      m_tuser <= {out_req.sw, out_req.kind};
      m_tlast <= out_req.last;
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.occ <= CNT_W'(DEPTH))
    else $error("timer store overfilled");

  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while another is in work");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_req.load |-> out_free)
    else $error("result overwritten before taken");

  a_switch_on_done: assert property (@(posedge clk) disable iff (rst)
    out_req.load && out_req.sw |-> out_req.kind == KIND_DONE && out_req.last)
    else $error("task switch flag outside tick done");

endmodule

`default_nettype wire
